@@ hdl/pcp_pkg.sv @@
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int LEN_W      = 20;
  localparam int SIZE_W     = 16;
  localparam int COUNT_W    = 3;
  localparam int IDX_OUT_W  = 2;
  localparam int STEP_W     = $clog2(LEN_W);
  localparam int NUM_SIZES_DEF = 4;

  // Register index of the size count; chunk size k sits at index k + 1.
  localparam int CFG_IDX_COUNT = 0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_CUR,
    S_LD_NXT,
    S_DIV,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic start;     // load a new length, restart at size 0
    logic ld_cur;    // capture current chunk size
    logic ld_nxt;    // capture next chunk size, seed the divider
    logic div_step;  // one restoring division step
    logic emit;      // load a group into the output register
    logic emit_last; // the emitted group closes the plan
    logic advance;   // remainder carries on to the next size
  } cmd_t;

  typedef struct packed {
    logic plan_empty; // incoming item yields no groups
    logic div_done;   // last division step is in progress
    logic finish;     // the plan ends at the current size
    logic full_nz;    // current size took at least one full chunk
    logic out_busy;   // output register holds a group not yet taken
  } status_t;

endpackage

@@ hdl/pcp_ctrl.sv @@
`timescale 1ns / 1ps

module pcp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pcp_pkg::status_t sts,
  output pcp_pkg::cmd_t    cmd,
  output pcp_pkg::state_t  state
);

  pcp_pkg::state_t state_r;
  pcp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcp_pkg::S_IDLE: begin
        if (in_valid && !sts.plan_empty) begin
          state_nxt = pcp_pkg::S_LD_CUR;
        end
      end
      pcp_pkg::S_LD_CUR: state_nxt = pcp_pkg::S_LD_NXT;
      pcp_pkg::S_LD_NXT: state_nxt = pcp_pkg::S_DIV;
      pcp_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = pcp_pkg::S_DECIDE;
        end
      end
      pcp_pkg::S_DECIDE: begin
        if (sts.finish) begin
          if (!sts.out_busy) begin
            state_nxt = pcp_pkg::S_IDLE;
          end
        end else if (!sts.full_nz || !sts.out_busy) begin
          state_nxt = pcp_pkg::S_LD_CUR;
        end
      end
      default: state_nxt = pcp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      pcp_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      pcp_pkg::S_LD_CUR: cmd.ld_cur = 1'b1;
      pcp_pkg::S_LD_NXT: cmd.ld_nxt = 1'b1;
      pcp_pkg::S_DIV:    cmd.div_step = 1'b1;
      pcp_pkg::S_DECIDE: begin
        if (sts.finish) begin
          cmd.emit      = !sts.out_busy;
          cmd.emit_last = 1'b1;
        end else if (!sts.full_nz) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.emit    = !sts.out_busy;
          cmd.advance = !sts.out_busy;
        end
      end
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  assign state = state_r;

endmodule

@@ hdl/pcp_dp.sv @@
`timescale 1ns / 1ps

module pcp_dp #(
  parameter int NUM_SIZES = pcp_pkg::NUM_SIZES_DEF,
  parameter int CFG_IW    = $clog2(NUM_SIZES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [CFG_IW-1:0]               cfg_index,
  input  logic [pcp_pkg::SIZE_W-1:0]      cfg_wdata,
  input  logic [pcp_pkg::LEN_W-1:0]       in_total_length,
  input  pcp_pkg::cmd_t                   cmd,
  output pcp_pkg::status_t                sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [pcp_pkg::IDX_OUT_W-1:0]   out_size_index,
  output logic [pcp_pkg::LEN_W-1:0]       out_full_count,
  output logic [pcp_pkg::SIZE_W-1:0]      out_partial_length,
  output logic                            out_last_group
);

  localparam int IDXW = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;
  localparam int LW   = pcp_pkg::LEN_W;
  localparam int SW   = pcp_pkg::SIZE_W;

  // Configuration registers.
  logic [pcp_pkg::COUNT_W-1:0] count_r;
  logic [SW-1:0]               size_r [NUM_SIZES];

  // Plan state and divider.
  logic [LW-1:0]                len_r;
  logic [IDXW-1:0]              idx_r;
  logic [SW:0]                  cur_r;
  logic [SW:0]                  nxt_r;
  logic [LW-1:0]                q_r;
  logic [SW-1:0]                rem_r;
  logic [pcp_pkg::STEP_W-1:0]   step_r;

  logic                         out_valid_r;
  logic [pcp_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic [LW-1:0]                out_full_r;
  logic [SW-1:0]                out_part_r;
  logic                         out_last_r;

  logic [3:0]    n_eff;
  logic [3:0]    idx_p1;
  logic          at_last;
  logic          nxt_exists;
  logic [IDXW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic [SW:0]   rd_size;
  logic [SW:0]   trial;
  logic          trial_ge;
  logic [SW-1:0] rem_nxt;
  logic          pass_on;
  logic          stay;
  logic          rem_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < NUM_SIZES; k++) begin
        size_r[k] <= SW'(1);
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IW'(pcp_pkg::CFG_IDX_COUNT)) begin
        count_r <= cfg_wdata[pcp_pkg::COUNT_W-1:0];
      end
      for (int k = 0; k < NUM_SIZES; k++) begin
        if (cfg_index == CFG_IW'(k + 1)) begin
          size_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // Count above the number of size registers is clamped.
  assign n_eff = ({1'b0, count_r} > 4'(NUM_SIZES)) ? 4'(NUM_SIZES) : {1'b0, count_r};
  assign idx_p1     = 4'(idx_r) + 4'd1;
  assign at_last    = (idx_p1 >= n_eff);
  assign nxt_exists = (idx_p1 < 4'(NUM_SIZES));

  // Single read port on the size registers; a zero size acts as size one.
  assign rd_addr = cmd.ld_nxt ? IDXW'(idx_p1) : idx_r;
  assign rd_data = size_r[rd_addr];
  assign rd_size = (rd_data == '0) ? (SW + 1)'(1) : {1'b0, rd_data};

  // Restoring division, one quotient bit per cycle, dividend shifts out of q_r.
  assign trial    = {rem_r, q_r[LW-1]};
  assign trial_ge = (trial >= cur_r);
  assign rem_nxt  = trial_ge ? SW'(trial - cur_r) : trial[SW-1:0];

  assign rem_zero = (rem_r == '0);
  assign pass_on  = ({nxt_r[SW-1:0], 1'b0} >= cur_r) && ({1'b0, rem_r} <= nxt_r);
  assign stay     = at_last || (!pass_on && ({rem_r, 1'b0} >= cur_r));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len_r <= in_total_length;
      idx_r <= '0;
    end else if (cmd.advance) begin
      len_r <= LW'(rem_r);
      idx_r <= IDXW'(idx_p1);
    end
    if (cmd.ld_cur) begin
      cur_r <= rd_size;
    end
    if (cmd.ld_nxt) begin
      nxt_r  <= nxt_exists ? rd_size : (SW + 1)'(1);
      q_r    <= len_r;
      rem_r  <= '0;
      step_r <= pcp_pkg::STEP_W'(LW - 1);
    end else if (cmd.div_step) begin
      q_r    <= {q_r[LW-2:0], trial_ge};
      rem_r  <= rem_nxt;
      step_r <= step_r - pcp_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= pcp_pkg::IDX_OUT_W'(idx_r);
      out_full_r <= q_r;
      out_part_r <= (cmd.emit_last && stay) ? rem_r : '0;
      out_last_r <= cmd.emit_last;
    end
  end

  assign sts.plan_empty = (in_total_length == '0) || (n_eff == 4'd0);
  assign sts.div_done   = (step_r == '0);
  assign sts.finish     = rem_zero || stay;
  assign sts.full_nz    = (q_r != '0);
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_size_index     = out_idx_r;
  assign out_full_count     = out_full_r;
  assign out_partial_length = out_part_r;
  assign out_last_group     = out_last_r;

endmodule

@@ hdl/prefill_chunk_planner.sv @@
`timescale 1ns / 1ps

// Prefill chunk planner.
// Write the size count (index 0) and the chunk sizes (index 1 and up, largest
// first) through the cfg port while the block is idle. Each input transfer
// carries one total token length; the block answers with one output transfer
// per chunk-size group: the size index, the number of full chunks and the
// length of a trailing partial chunk, with out_last_group set on the final one.
// A zero length or a zero size count produces no output transfers.
// For every size visited the planner fetches the current and next sizes, runs
// the one-bit-per-cycle restoring divider and then decides; once the plan is
// done it returns to idle before it takes the next length.
// in_stall is low only while idle, so one length is planned at a time. Results
// sit in an output register; while out_stall holds a group there, the planner
// waits in its decision step before it emits. The final group of a plan may
// still wait there while the next length is already being accepted.
// Reset (rst_n low, synchronous) clears the size count to zero, sets all sizes
// to one, drops any plan in progress and empties the output register.
module prefill_chunk_planner #(
  parameter int NUM_SIZES = pcp_pkg::NUM_SIZES_DEF,
  parameter int CFG_IW    = $clog2(NUM_SIZES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [pcp_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pcp_pkg::LEN_W-1:0]     in_total_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pcp_pkg::IDX_OUT_W-1:0] out_size_index,
  output logic [pcp_pkg::LEN_W-1:0]     out_full_count,
  output logic [pcp_pkg::SIZE_W-1:0]    out_partial_length,
  output logic                          out_last_group
);

  pcp_pkg::cmd_t    cmd;
  pcp_pkg::status_t sts;
  pcp_pkg::state_t  state;

  // The controller sequences fetch, divide and decide for each size.
  pcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // The datapath holds the size registers, the divider and the output register.
  pcp_dp #(
    .NUM_SIZES (NUM_SIZES),
    .CFG_IW    (CFG_IW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_total_length    (in_total_length),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_size_index     (out_size_index),
    .out_full_count     (out_full_count),
    .out_partial_length (out_partial_length),
    .out_last_group     (out_last_group)
  );

  // A partial chunk only ever appears on the closing group of a plan.
  a_partial_only_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_partial_length != '0) |-> out_last_group)
    else $error("partial chunk on a non-final group");

  // A zero-length transfer must leave the planner idle.
  a_zero_len_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_total_length == '0) |=> state == pcp_pkg::S_IDLE)
    else $error("zero length started a plan");

  // While a non-final group waits, its plan is still running.
  a_open_plan_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_group |-> state != pcp_pkg::S_IDLE)
    else $error("plan ended without a final group");

endmodule

@@ verif/tb_prefill_chunk_planner.sv @@
`timescale 1ns / 1ps

module tb_prefill_chunk_planner;

  localparam int NUM_SIZES = pcp_pkg::NUM_SIZES_DEF;
  localparam int CFG_IW = $clog2(NUM_SIZES + 1);

  // Register map: the size count first, then one register per chunk size.
  // Codes above the last size register exist on the port but select nothing.
  localparam int REG_COUNT = pcp_pkg::CFG_IDX_COUNT;
  localparam int REG_SIZE_BASE = REG_COUNT + 1;
  localparam int REG_FIRST_UNUSED = REG_SIZE_BASE + NUM_SIZES;
  localparam int REG_LAST_CODE = (1 << CFG_IW) - 1;

  localparam int unsigned MAX_LEN = (1 << pcp_pkg::LEN_W) - 1;
  localparam int unsigned MAX_SIZE = (1 << pcp_pkg::SIZE_W) - 1;

  // The slowest plan visits every size and then returns to idle.
  localparam int PLAN_LATENCY = 23 * NUM_SIZES + 1;
  localparam int SETTLE_CYCLES = PLAN_LATENCY + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 25;

  typedef enum int {
    SHAPE_CLOSE,   // each size at least half the one before it
    SHAPE_SPREAD,  // descending, with any ratio
    SHAPE_ANY      // no order at all, zeros allowed
  } size_shape_t;

  // One run-length group of a plan, as it leaves the block.
  typedef struct packed {
    logic [pcp_pkg::IDX_OUT_W-1:0] size_index;
    logic [pcp_pkg::LEN_W-1:0]     full_count;
    logic [pcp_pkg::SIZE_W-1:0]    partial_length;
    logic                          last_group;
  } chunk_group_t;

  // Keeps a private copy of the size registers, plans every accepted length
  // the way the block should, and holds the groups still owed by the block.
  class plan_checker;
    logic [pcp_pkg::COUNT_W-1:0] size_count;
    logic [pcp_pkg::SIZE_W-1:0]  chunk_size [NUM_SIZES];
    chunk_group_t                planned_groups [$];
    int                          mismatch_count;

    function new();
      size_count = '0;
      foreach (chunk_size[k]) chunk_size[k] = 1;
      mismatch_count = 0;
    endfunction

    function void write_reg(int idx, logic [pcp_pkg::SIZE_W-1:0] data);
      if (idx == REG_COUNT) begin
        size_count = data[pcp_pkg::COUNT_W-1:0];
      end else if (idx >= REG_SIZE_BASE && idx < REG_FIRST_UNUSED) begin
        chunk_size[idx - REG_SIZE_BASE] = data;
      end
    endfunction

    function int pending();
      return planned_groups.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    // Greedy split of one length. A group is only queued once the next one
    // is known, so that the final group can carry the last flag.
    function void note_length(logic [pcp_pkg::LEN_W-1:0] total);
      int unsigned  left, used, cur, nxt, full, rem;
      bit           stay, held;
      chunk_group_t pend, g;
      left = total;
      used = (size_count > NUM_SIZES) ? NUM_SIZES : size_count;
      held = 1'b0;
      pend = '0;
      for (int i = 0; i < used && left > 0; i++) begin
        cur = (chunk_size[i] == 0) ? 1 : chunk_size[i];
        full = left / cur;
        rem = left % cur;
        g.size_index = i[pcp_pkg::IDX_OUT_W-1:0];
        g.full_count = full[pcp_pkg::LEN_W-1:0];
        g.last_group = 1'b0;
        if (rem == 0) begin
          stay = 1'b1;
        end else if (i + 1 >= used) begin
          stay = 1'b1;
        end else begin
          nxt = (chunk_size[i + 1] == 0) ? 1 : chunk_size[i + 1];
          if (nxt * 2 >= cur && rem <= nxt) stay = 1'b0;
          else stay = (rem * 2 >= cur);
        end
        if (stay) begin
          g.partial_length = rem[pcp_pkg::SIZE_W-1:0];
          left = 0;
        end else begin
          g.partial_length = '0;
          left = rem;
        end
        // A size that passes everything on without a full chunk adds nothing.
        if (stay || full > 0) begin
          if (held) planned_groups = {planned_groups, pend};
          pend = g;
          held = 1'b1;
        end
      end
      if (held) begin
        pend.last_group = 1'b1;
        planned_groups = {planned_groups, pend};
      end
    endfunction

    task check_group(chunk_group_t got);
      chunk_group_t want;
      if (planned_groups.size() == 0) begin
        report_mismatch($sformatf("group with nothing outstanding: idx %0d full %0d part %0d",
                                  got.size_index, got.full_count, got.partial_length));
        return;
      end
      want = planned_groups.pop_front();
      if (got.size_index !== want.size_index)
        report_mismatch($sformatf("size_index %0d, want %0d", got.size_index, want.size_index));
      if (got.full_count !== want.full_count)
        report_mismatch($sformatf("full_count %0d, want %0d", got.full_count, want.full_count));
      if (got.partial_length !== want.partial_length)
        report_mismatch($sformatf("partial_length %0d, want %0d",
                                  got.partial_length, want.partial_length));
      if (got.last_group !== want.last_group)
        report_mismatch($sformatf("last_group %0b, want %0b", got.last_group, want.last_group));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [CFG_IW-1:0]             cfg_index;
  logic [pcp_pkg::SIZE_W-1:0]    cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [pcp_pkg::LEN_W-1:0]     in_total_length;
  logic                          out_valid;
  logic                          out_stall;
  logic [pcp_pkg::IDX_OUT_W-1:0] out_size_index;
  logic [pcp_pkg::LEN_W-1:0]     out_full_count;
  logic [pcp_pkg::SIZE_W-1:0]    out_partial_length;
  logic                          out_last_group;

  plan_checker  plan_sb;
  int unsigned  length_q [$];
  int unsigned  cfg_sizes [NUM_SIZES];
  int           stall_pct;
  bit           hold_off_req;
  int           idle_cycles;

  prefill_chunk_planner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_total_length    (in_total_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_size_index     (out_size_index),
    .out_full_count     (out_full_count),
    .out_partial_length (out_partial_length),
    .out_last_group     (out_last_group)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both monitors sample at the rising edge, before any nonblocking update of
  // that edge lands, so they see exactly what the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) plan_sb.note_length(in_total_length);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      plan_sb.check_group({out_size_index, out_full_count, out_partial_length, out_last_group});
  end

  // The watchdog restarts on every transfer on either channel. A run that goes
  // quiet for too long means a lost group or a hung planner.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure. Random stall bursts come at the rate that the
  // stimulus sets; a hold-off request stalls the result channel once for a
  // long stretch so that the output register fills and the input side backs up.
  initial begin : result_backpressure
    int burst;
    bit held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
        out_stall <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Writes the size count and every size register from cfg_sizes, optionally
  // preceded by a write to an unused register code that must change nothing.
  // Only called while the planner is idle.
  task automatic program_sizes(input int unsigned count, input bit stray);
    int          idx_q [$];
    int unsigned data_q [$];
    if (stray) begin
      idx_q = {idx_q, int'($urandom_range(REG_FIRST_UNUSED, REG_LAST_CODE))};
      data_q = {data_q, $urandom_range(0, MAX_SIZE)};
    end
    idx_q = {idx_q, REG_COUNT};
    data_q = {data_q, count};
    for (int k = 0; k < NUM_SIZES; k++) begin
      idx_q = {idx_q, REG_SIZE_BASE + k};
      data_q = {data_q, cfg_sizes[k]};
    end
    foreach (idx_q[n]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IW'(idx_q[n]);
      cfg_wdata <= pcp_pkg::SIZE_W'(data_q[n]);
      @(posedge clk);
      plan_sb.write_reg(idx_q[n], pcp_pkg::SIZE_W'(data_q[n]));
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offers every queued length, one transfer each, with random gaps between
  // transfers when asked. Valid stays up across back-to-back transfers.
  task automatic offer_lengths(input bit gaps);
    int gap;
    while (length_q.size() > 0) begin
      in_valid <= 1'b1;
      in_total_length <= pcp_pkg::LEN_W'(length_q.pop_front());
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (gaps && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every planned group has come back, then lets a full plan time
  // pass, since a zero-size plan or one that emits nothing can still be busy.
  task automatic settle();
    @(posedge clk);
    while (plan_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned count, len, unit, pick;
    size_shape_t shape;
    bit          gaps;

    plan_sb = new();
    stall_pct = 0;
    hold_off_req = 1'b0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_total_length <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset no size is in use, so these lengths produce nothing.
    length_q = '{100, 0, MAX_LEN};
    offer_lengths(1'b1);
    settle();

    // Sizes that each halve: remainders move down a size when they fit, or
    // stay as a partial chunk when they are at least half the current size.
    stall_pct = 25;
    cfg_sizes = '{1024, 512, 256, 128};
    program_sizes(4, 1'b0);
    length_q = '{0, 1, 1024, 2048, 1023, 1500, 700, 300, 130, 129, MAX_LEN};
    offer_lengths(1'b1);
    settle();

    // Sizes far apart: small remainders fall through to smaller sizes, and a
    // size that takes nothing must not show up as a group.
    cfg_sizes = '{4096, 1000, 100, 3};
    program_sizes(4, 1'b1);
    length_q = '{5000, 4500, 4097};
    offer_lengths(1'b0);
    settle();

    // Count above the number of sizes is clamped, and a zero size acts as one.
    // The largest size also gives the largest possible partial chunk.
    cfg_sizes = '{MAX_SIZE, 0, 5, 5};
    program_sizes(7, 1'b1);
    length_q = '{MAX_LEN, MAX_SIZE - 1, 0};
    offer_lengths(1'b1);
    settle();

    // Ascending sizes: the same rule runs in register order.
    cfg_sizes = '{3, 10, 0, 0};
    program_sizes(2, 1'b0);
    length_q = '{7, 30, 2};
    offer_lengths(1'b1);
    settle();

    // A single size of one token gives the largest full-chunk count.
    cfg_sizes = '{1, 0, 0, 0};
    program_sizes(1, 1'b0);
    length_q = '{MAX_LEN, 1};
    offer_lengths(1'b0);
    settle();

    // Random phases, each with its own size table. Most tables are well
    // ordered so that the pass-down rule gets exercised; some are not.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, NUM_SIZES) : $urandom_range(0, 7);
      pick = $urandom_range(0, 3);
      shape = (pick < 2) ? SHAPE_CLOSE : ((pick == 2) ? SHAPE_SPREAD : SHAPE_ANY);
      cfg_sizes[0] = $urandom_range(1, (1 << $urandom_range(1, pcp_pkg::SIZE_W)) - 1);
      for (int k = 1; k < NUM_SIZES; k++) begin
        if (shape == SHAPE_ANY)
          cfg_sizes[k] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_SIZE);
        else if (cfg_sizes[k - 1] < 2)
          cfg_sizes[k] = 1;
        else if (shape == SHAPE_SPREAD)
          cfg_sizes[k] = $urandom_range(1, cfg_sizes[k - 1] - 1);
        else
          cfg_sizes[k] = $urandom_range((cfg_sizes[k - 1] + 1) / 2, cfg_sizes[k - 1] - 1);
      end
      if (shape == SHAPE_ANY && $urandom_range(0, 1) == 1) cfg_sizes[0] = 0;
      program_sizes(count, $urandom_range(0, 2) == 0);

      unit = (cfg_sizes[0] == 0) ? 1 : cfg_sizes[0];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) len = $urandom_range(1, unit * 5);
        else if (pick < 11) len = unit * $urandom_range(1, 16) + $urandom_range(0, 2);
        else if (pick < 16) len = $urandom();
        else if (pick < 17) len = 0;
        else len = $urandom_range(1, 40);
        length_q = {length_q, len & MAX_LEN};
      end

      // Every third phase and the closing one run without any idling.
      gaps = (phase != RANDOM_PHASES - 1) && (phase % 3 != 2);
      stall_pct = gaps ? 25 : 0;
      if (phase == 1) hold_off_req = 1'b1;
      offer_lengths(gaps);
      settle();
    end

    if (plan_sb.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pcp_pkg.sv
hdl/pcp_ctrl.sv
hdl/pcp_dp.sv
hdl/prefill_chunk_planner.sv
verif/tb_prefill_chunk_planner.sv
